// File: hdl/vnorm_pkg.sv
// shared widths and sideband types for the vector normalize pipeline
// no dependencies
package vnorm_pkg;

  localparam int COMP_W     = 32;            // input component width
  localparam int SQ_W       = 2 * COMP_W;    // squared length width
  localparam int ROOT_W     = SQ_W / 2;      // square root width
  localparam int REM_W      = ROOT_W + 1;    // root remainder width
  localparam int UNIT_SHIFT = 30;            // unit output fraction bits
  localparam int QUO_W      = UNIT_SHIFT + 1;
  localparam int IN_W       = 3 * COMP_W;
  localparam int OUT_W      = 4 * COMP_W;

  // per-item data carried beside the square root pipeline
  typedef struct packed {
    logic [2:0][COMP_W-1:0] mag;
    logic [2:0]             neg;
    logic                   zero;
  } sqrt_side_t;

  // per-item data carried beside the divider pipeline
  typedef struct packed {
    logic [ROOT_W-1:0] len;
    logic [2:0]        neg;
    logic              zero;
  } div_side_t;

endpackage

// File: hdl/vnorm_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on vnorm_pkg; quotient is num * 2^30 / den for num <= den
module vnorm_div import vnorm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [COMP_W-1:0] num,
  input  logic [COMP_W-1:0] den,
  output logic [QUO_W-1:0]  quo
);

  logic [COMP_W-1:0] rem [QUO_W];
  logic [COMP_W-1:0] dd  [QUO_W];
  logic [QUO_W-1:0]  qq  [QUO_W];

  // leading bit: set when num is at least den, so only when num equals den for num <= den
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (num >= den) ? (num - den) : num;
      qq[0]  <= {{(QUO_W-1){1'b0}}, (num >= den)};
      dd[0]  <= den;
    end
  end

  for (genvar k = 1; k < QUO_W; k++) begin : g_step
    logic [COMP_W:0] r;
    logic [COMP_W:0] diff;
    logic            ge;
    assign r    = {rem[k-1], 1'b0};
    assign diff = r - {1'b0, dd[k-1]};
    assign ge   = (r >= {1'b0, dd[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[COMP_W-1:0] : r[COMP_W-1:0];
        qq[k]  <= {qq[k-1][QUO_W-2:0], ge};
        dd[k]  <= dd[k-1];
      end
    end
  end

  assign quo = qq[QUO_W-1];

endmodule

// File: hdl/vec3_normalize_unit.sv
// Normalizes one signed Q15.16 vector per clock, while the output is not stalled, to
// Q1.30 unit components plus its Q16.16 length. Fully pipelined: a new word is taken
// every cycle unless the output stalls. Stages in order: magnitudes, squares and sum,
// the square root at one root bit per stage, the three dividers at one quotient bit
// per stage, and an output register. A stalled output holds the whole pipeline. A
// zero vector gives zero outputs with is_zero set.
// depends on vnorm_pkg and vnorm_div
module vec3_normalize_unit import vnorm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // x_in, y_in, z_in
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // x_unit, y_unit, z_unit, length
  output logic [0:0]       m_tuser    // is_zero
);

  localparam int LAT = 3 + ROOT_W + QUO_W;

  logic en;
  logic [LAT:1] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[LAT-1:1], s_tvalid};
      m_tvalid <= vld[LAT];
    end
  end

  // front end: magnitudes, squares, sum
  logic [2:0][COMP_W-1:0] mag1, mag2;
  logic [2:0]             neg1, neg2;
  logic [2:0][SQ_W-1:0]   sqp2;
  logic                   zero2;
  logic [SQ_W-1:0]        sum3;
  sqrt_side_t             side3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= s_tdata[i*COMP_W + COMP_W-1];
        mag1[i] <= s_tdata[i*COMP_W + COMP_W-1]
                   ? (COMP_W'(0) - s_tdata[i*COMP_W +: COMP_W])
                   : s_tdata[i*COMP_W +: COMP_W];
        sqp2[i] <= SQ_W'(mag1[i]) * SQ_W'(mag1[i]);
      end
      mag2       <= mag1;
      neg2       <= neg1;
      zero2      <= (mag1 == '0);
      sum3       <= sqp2[0] + sqp2[1] + sqp2[2];
      side3.mag  <= mag2;
      side3.neg  <= neg2;
      side3.zero <= zero2;
    end
  end

  // square root: two radicand bits in per stage
  logic [REM_W-1:0]  srem  [ROOT_W+1];
  logic [ROOT_W-1:0] sroot [ROOT_W+1];
  logic [SQ_W-1:0]   sdat  [ROOT_W+1];
  sqrt_side_t        sside [ROOT_W+1];

  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sdat[0]  = sum3;
  assign sside[0] = side3;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W+1:0] r;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;
    assign r     = {srem[k], sdat[k][SQ_W-1 -: 2]};
    assign trial = {1'b0, sroot[k], 2'b01};
    assign diff  = r - trial;
    assign ge    = (r >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        srem[k+1]  <= ge ? diff[REM_W-1:0] : r[REM_W-1:0];
        sroot[k+1] <= {sroot[k][ROOT_W-2:0], ge};
        sdat[k+1]  <= {sdat[k][SQ_W-3:0], 2'b00};
        sside[k+1] <= sside[k];
      end
    end
  end

  // dividers, with the sideband delayed to match
  logic [2:0][QUO_W-1:0] quo;
  div_side_t             dside [QUO_W+1];

  assign dside[0].len  = sroot[ROOT_W];
  assign dside[0].neg  = sside[ROOT_W].neg;
  assign dside[0].zero = sside[ROOT_W].zero;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vnorm_div u_div (
      .clk (clk),
      .en  (en),
      .num (sside[ROOT_W].mag[i]),
      .den (sroot[ROOT_W]),
      .quo (quo[i])
    );
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_dside
    always_ff @(posedge clk) begin
      if (en) begin
        dside[k+1] <= dside[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dside[QUO_W].zero) begin
          m_tdata[i*COMP_W +: COMP_W] <= '0;
        end else if (dside[QUO_W].neg[i]) begin
          m_tdata[i*COMP_W +: COMP_W] <= COMP_W'(0) - COMP_W'(quo[i]);
        end else begin
          m_tdata[i*COMP_W +: COMP_W] <= COMP_W'(quo[i]);
        end
      end
      m_tdata[3*COMP_W +: COMP_W] <= dside[QUO_W].len;
      m_tuser[0]                  <= dside[QUO_W].zero;
    end
  end

  // zero vector gives all-zero data
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("zero vector with nonzero output");

  // nonzero vector has nonzero length
  a_len_nz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[3*COMP_W +: COMP_W] != '0)
    else $error("nonzero vector with zero length");

  // unit components stay within one
  a_unit_rng: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824 &&
                  $signed(m_tdata[31:0]) >= -32'sd1073741824 &&
                  $signed(m_tdata[63:32]) <= 32'sd1073741824 &&
                  $signed(m_tdata[63:32]) >= -32'sd1073741824 &&
                  $signed(m_tdata[95:64]) <= 32'sd1073741824 &&
                  $signed(m_tdata[95:64]) >= -32'sd1073741824))
    else $error("unit component out of range");

  // a stalled output freezes the pipeline
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule

// File: dv/vec3_normalize_unit_test.sv
// testbench for vec3_normalize_unit: random and directed vectors streamed in,
// results checked against an in-bench normalize predictor
// depends on vnorm_pkg and the vec3_normalize_unit rtl
`timescale 1ns / 1ps
module vec3_normalize_unit_test;
  import vnorm_pkg::*;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } vec_t;

  typedef struct {
    logic [31:0] xu, yu, zu, len;
    logic        zero;
  } unit_t;

  logic             clk = 0;
  logic             rst = 1;
  logic             s_tvalid = 0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0]       m_tuser;

  vec3_normalize_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  vec_t  pending_vecs[$];
  unit_t expected_units[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_cycles = 0;
  int    errors = 0;
  longint cycles = 0;
  bit    stim_done = 0;

  function automatic logic [63:0] root64(logic [63:0] op);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > op) b >>= 2;
    while (b != 0) begin
      if (op >= res + b) begin
        op -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic unit_t normalize(vec_t v);
    unit_t r;
    logic [2:0][31:0] comp;
    logic [63:0] mag[3];
    logic [63:0] sq, len, q;
    logic [31:0] u[3];
    comp = {v.z, v.y, v.x};
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][31] ? 64'h1_0000_0000 - {32'd0, comp[i]} : {32'd0, comp[i]};
      sq += mag[i] * mag[i];
    end
    if (sq == 0) begin
      r = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
      return r;
    end
    len = root64(sq);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << UNIT_SHIFT) / len;
      u[i] = comp[i][31] ? 32'(64'h1_0000_0000 - q) : q[31:0];
    end
    r = '{u[0], u[1], u[2], len[31:0], 1'b0};
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver: valid stays high until the word is taken
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (pending_vecs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          vec_t v;
          v = pending_vecs.pop_front();
          expected_units.push_back(normalize(v));
          s_tdata <= v;
          s_tvalid <= 1;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_units.size() == 0) begin
          report("unexpected word", m_tdata[31:0], 32'd0);
        end else begin
          unit_t e;
          e = expected_units.pop_front();
          if (m_tdata[31:0] !== e.xu) report("x_unit", m_tdata[31:0], e.xu);
          if (m_tdata[63:32] !== e.yu) report("y_unit", m_tdata[63:32], e.yu);
          if (m_tdata[95:64] !== e.zu) report("z_unit", m_tdata[95:64], e.zu);
          if (m_tdata[127:96] !== e.len) report("length", m_tdata[127:96], e.len);
          if (m_tuser[0] !== e.zero)
            report("is_zero", {31'd0, m_tuser[0]}, {31'd0, e.zero});
        end
      end
      m_tready <= hold_cycles > 0 ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("vec3_normalize_unit test failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom_range(255) - 128;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    while (pending_vecs.size() != 0 || s_tvalid || expected_units.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    vec_t v;
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed: zero, unit axes, extremes, a component equal to the length
    pending_vecs.push_back('{32'd0, 32'd0, 32'd0});
    pending_vecs.push_back('{32'd0, 32'd0, 32'h0001_0000});
    pending_vecs.push_back('{32'd0, 32'hffff_0000, 32'd0});
    pending_vecs.push_back('{32'h0000_0001, 32'd0, 32'd0});
    pending_vecs.push_back('{32'd0, 32'd0, 32'hffff_ffff});
    pending_vecs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    pending_vecs.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    pending_vecs.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001});
    pending_vecs.push_back('{32'h0000_0001, 32'h0000_0001, 32'h0000_0001});
    pending_vecs.push_back('{32'h0000_0002, 32'hffff_fffe, 32'h0000_0001});
    pending_vecs.push_back('{32'd0, 32'h0004_0000, 32'hfffd_0000});
    pending_vecs.push_back('{32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0000});
    drain();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1 || p == 3) ? (p == 1 ? 75 : 23) : 0;
      recv_stall_pct = (p == 2 || p == 3) ? (p == 2 ? 75 : 23) : 0;
      // receiver holds off long enough for the pipe to fill and back up
      if (p == 0) hold_cycles = 200;
      for (int i = 0; i < 110; i++) begin
        v = '{rand_comp(), rand_comp(), rand_comp()};
        pending_vecs.push_back(v);
      end
      drain();
    end
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("vec3_normalize_unit test passed");
    end else begin
      $display("vec3_normalize_unit test failed");
    end
    $finish;
  end
endmodule
